// ----- design/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with all-or-nothing bursts.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Default number of byte entries
    localparam int DEPTH_DEF = 64;

    // Fixed field widths
    localparam int ACT_W  = 2;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 7;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // One result waiting to be sent (read byte comes from the RAM)
    typedef struct packed {
        logic             is_data;
        logic [LEN_W-1:0] count;
        logic             last;
        logic [LEN_W-1:0] fill;
    } result_t;

endpackage

// ----- design/brf_ram.sv -----
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds its value while no read is issued.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/byte_ring_fifo_burst_top.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_top
// Circular byte FIFO with all-or-nothing write bursts, read requests of N
// bytes and a clear action. Bytes live in one registered-read RAM.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_stall  | action, data_byte, first_of_burst, burst_len
//   output  | out_valid / out_stall| data_out, count, is_read_data, last,
//           |                      | fill_level
//
// Write bytes, clears and rejected requests each complete in one input transfer.
// An accepted read of N bytes issues N RAM reads via the single read port, one
// per cycle while the pending stage is free; next input waits for the last one.
// One pending stage sits behind the output register, so one result may wait
// on a stalled output while the next input transfer is taken.
// Reset (async, rst_n low) clears pointers, fill level and burst state;
// the byte RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_top #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [brf_pkg::ACT_W-1:0]  action,
    input  logic [brf_pkg::DATA_W-1:0] data_byte,
    input  logic                       first_of_burst,
    input  logic [brf_pkg::LEN_W-1:0]  burst_len,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [brf_pkg::DATA_W-1:0] data_out,
    output logic [brf_pkg::LEN_W-1:0]  count,
    output logic                       is_read_data,
    output logic                       last,
    output logic [brf_pkg::LEN_W-1:0]  fill_level
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int LEN_W  = brf_pkg::LEN_W;
    localparam int DATA_W = brf_pkg::DATA_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(DEPTH);
    localparam logic [LEN_W-1:0]  DEPTH_LEN  = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0]  LEN_ONE    = LEN_W'(1);

    // Control state
    logic                  st_reg,        st_next;
    logic [PTR_W-1:0]      rd_ptr_reg,    rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg,    wr_ptr_next;
    logic [FILL_W-1:0]     fill_reg,      fill_next;
    logic [LEN_W-1:0]      rem_reg,       rem_next;
    logic                  drop_reg,      drop_next;
    logic [LEN_W-1:0]      total_reg,     total_next;
    logic [LEN_W-1:0]      left_reg,      left_next;
    logic [LEN_W-1:0]      rlen_reg,      rlen_next;

    // Pending stage and output register
    logic                  p_vld_reg,     p_vld_next;
    brf_pkg::result_t      p_res_reg,     p_res_next;
    logic                  o_vld_reg,     o_vld_next;
    brf_pkg::result_t      o_res_reg,     o_res_next;
    logic [DATA_W-1:0]     o_data_reg,    o_data_next;

    // RAM port signals
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [DATA_W-1:0]     ram_rd_data;

    logic                  p_move;
    logic                  p_free;
    logic                  in_acc;
    logic                  out_acc;

    // Burst working values for a write byte
    logic                  wr_live;
    logic [LEN_W-1:0]      eff_rem;
    logic                  eff_drop;
    logic [LEN_W-1:0]      eff_total;
    logic [LEN_W-1:0]      free_len;
    logic [LEN_W-1:0]      fill_len;

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Handshake
    assign out_acc  = o_vld_reg && !out_stall;
    assign p_move   = p_vld_reg && (!o_vld_reg || !out_stall);
    assign p_free   = !p_vld_reg || p_move;
    assign in_stall = (st_reg != ST_IDLE) || !p_free;
    assign in_acc   = in_valid && !in_stall;

    assign fill_len = LEN_W'(fill_reg);
    assign free_len = DEPTH_LEN - fill_len;

    // Burst bookkeeping for the current write byte
    always_comb
    begin
        wr_live   = first_of_burst || (rem_reg != '0);
        eff_rem   = first_of_burst ? burst_len : rem_reg;
        eff_drop  = first_of_burst ? (burst_len > free_len) : drop_reg;
        eff_total = first_of_burst ? burst_len : total_reg;
    end

    // Main sequencer
    always_comb
    begin
        st_next     = st_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        drop_next   = drop_reg;
        total_next  = total_reg;
        left_next   = left_reg;
        rlen_next   = rlen_reg;
        p_vld_next  = p_vld_reg && !p_move;
        p_res_next  = p_res_reg;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (action)
                        brf_pkg::ACT_WRITE:
                        begin
                            if (first_of_burst && (burst_len == '0))
                            begin
                                // zero-length burst: drop and report
                                rem_next   = '0;
                                drop_next  = 1'b0;
                                total_next = '0;
                                p_vld_next = 1'b1;
                                p_res_next = '{is_data: 1'b0, count: '0, last: 1'b1,
                                               fill: fill_len};
                            end
                            else if (wr_live)
                            begin
                                logic [FILL_W-1:0] f;
                                f = fill_reg;
                                if (!eff_drop && (fill_reg != FILL_FULL))
                                begin
                                    ram_wr_en   = 1'b1;
                                    wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0
                                                  : wr_ptr_reg + 1'b1;
                                    f           = fill_reg + 1'b1;
                                end
                                fill_next = f;
                                rem_next  = eff_rem - 1'b1;
                                if (eff_rem == LEN_ONE)
                                begin
                                    // end of burst
                                    drop_next  = 1'b0;
                                    total_next = '0;
                                    p_vld_next = 1'b1;
                                    p_res_next = '{is_data: 1'b0,
                                                   count: eff_drop ? '0 : eff_total,
                                                   last: 1'b1, fill: LEN_W'(f)};
                                end
                                else
                                begin
                                    drop_next  = eff_drop;
                                    total_next = eff_total;
                                end
                            end
                        end
                        brf_pkg::ACT_READ:
                        begin
                            if ((burst_len == '0) || (burst_len > fill_len))
                            begin
                                p_vld_next = 1'b1;
                                p_res_next = '{is_data: 1'b0, count: '0, last: 1'b1,
                                               fill: fill_len};
                            end
                            else
                            begin
                                // first byte read issues now
                                fill_next   = fill_reg - FILL_W'(burst_len);
                                ram_rd_en   = 1'b1;
                                rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0
                                              : rd_ptr_reg + 1'b1;
                                rlen_next   = burst_len;
                                left_next   = burst_len - 1'b1;
                                st_next     = (burst_len == LEN_ONE) ? ST_IDLE : ST_READ;
                                p_vld_next  = 1'b1;
                                p_res_next  = '{is_data: 1'b1, count: burst_len,
                                                last: (burst_len == LEN_ONE),
                                                fill: fill_len - burst_len};
                            end
                        end
                        brf_pkg::ACT_CLEAR:
                        begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            fill_next   = '0;
                            rem_next    = '0;
                            drop_next   = 1'b0;
                            total_next  = '0;
                            p_vld_next  = 1'b1;
                            p_res_next  = '{is_data: 1'b0, count: '0, last: 1'b1,
                                            fill: '0};
                        end
                        default:
                        begin
                            // unused action: no effect
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // one RAM read per cycle while the pending stage frees up
                if (p_free)
                begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    left_next   = left_reg - 1'b1;
                    p_vld_next  = 1'b1;
                    p_res_next  = '{is_data: 1'b1, count: rlen_reg,
                                    last: (left_reg == LEN_ONE), fill: fill_len};
                    if (left_reg == LEN_ONE)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Output register load
    always_comb
    begin
        o_vld_next  = o_vld_reg && !out_acc;
        o_res_next  = o_res_reg;
        o_data_next = o_data_reg;
        if (p_move)
        begin
            o_vld_next  = 1'b1;
            o_res_next  = p_res_reg;
            o_data_next = p_res_reg.is_data ? ram_rd_data : '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            rem_reg    <= '0;
            drop_reg   <= 1'b0;
            total_reg  <= '0;
            left_reg   <= '0;
            p_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            rem_reg    <= rem_next;
            drop_reg   <= drop_next;
            total_reg  <= total_next;
            left_reg   <= left_next;
            p_vld_reg  <= p_vld_next;
            o_vld_reg  <= o_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rlen_reg   <= rlen_next;
        p_res_reg  <= p_res_next;
        o_res_reg  <= o_res_next;
        o_data_reg <= o_data_next;
    end

    assign out_valid    = o_vld_reg;
    assign data_out     = o_data_reg;
    assign count        = o_res_reg.count;
    assign is_read_data = o_res_reg.is_data;
    assign last         = o_res_reg.last;
    assign fill_level   = o_res_reg.fill;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill level above capacity");

    a_read_left: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_READ) |-> (left_reg != '0))
        else $error("read sequencer active with nothing left");

    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p_vld_reg && p_res_reg.is_data && !p_move) |=> $stable(ram_rd_data))
        else $error("read data changed under a waiting result");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (fill_reg != FILL_FULL) && !ram_rd_en)
        else $error("byte stored into a full FIFO or alongside a read");

endmodule
